[hw/rtl/fcr_pkg.sv]
`timescale 1ns / 1ps

package fcr_pkg;

    // fixed field widths
    localparam int LBA_W   = 12;
    localparam int CNT_W   = 12;
    localparam int CYL_W   = 7;
    localparam int SEC_W   = 5;
    localparam int DMA_W   = 14;
    localparam int BYTE_W  = 8;

    // sectors per track fits 6 bits over its whole range
    localparam int TRK_W   = 6;

    // chunk limit per request
    localparam int MAX_RESULTS = 58;
    localparam int K_W         = 6;

    // lba over the track length by reciprocal multiply, exact for any 12-bit lba
    // and track lengths up to 63; the remainder settles on the divide step after the quotient
    localparam int DIV_STEPS   = 2;
    localparam int STEP_W      = 1;
    localparam int RECIP_SHIFT = 18;
    localparam int RECIP_W     = 19;
    localparam int PROD_W      = 30;

    // 512-byte sectors: low bits of the byte count minus one are all ones
    localparam int          BLK_SHIFT    = 9;
    localparam logic [8:0]  BLK_LOW_ONES = 9'h1FF;

    // controller command opcodes
    localparam logic [BYTE_W-1:0] OP_WRITE_DATA = 8'h45;
    localparam logic [BYTE_W-1:0] OP_READ_DATA  = 8'h46;

    // dma mode bytes
    localparam logic [BYTE_W-1:0] DMA_DEV_TO_MEM = 8'h46;
    localparam logic [BYTE_W-1:0] DMA_MEM_TO_DEV = 8'h4A;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic div_step;
        logic emit;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic chunk_last;
    } t_status;

endpackage

[hw/rtl/fcr_ctrl.sv]
`timescale 1ns / 1ps

module fcr_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    input  fcr_pkg::t_status i_status,
    output fcr_pkg::t_cmd   o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_EMIT
    } t_state;

    t_state                     r_state;
    logic [fcr_pkg::STEP_W-1:0] r_step;
    logic                       r_out_valid;
    logic                       slot_free;

    assign slot_free   = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            S_IDLE: o_cmd.load     = i_in_valid;
            S_DIV:  o_cmd.div_step = 1'b1;
            S_EMIT: o_cmd.emit     = slot_free;
            default: o_cmd = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    r_step <= '0;
                    if (i_in_valid) begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_step <= r_step + 1'b1;
                    if (r_step == fcr_pkg::STEP_W'(fcr_pkg::DIV_STEPS - 1)) begin
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (slot_free && i_status.chunk_last) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

[hw/rtl/fcr_dpath.sv]
`timescale 1ns / 1ps

module fcr_dpath #(
    parameter int TOTAL_SECTORS = 2880,
    parameter int TRACK_SECTORS = 18,
    parameter int MAX_REQUEST   = 1024
) (
    input  logic                              i_clk,
    input  fcr_pkg::t_cmd                     i_cmd,
    output fcr_pkg::t_status                  o_status,
    input  logic [fcr_pkg::LBA_W-1:0]         i_start_lba,
    input  logic [fcr_pkg::CNT_W-1:0]         i_sector_count,
    input  logic                              i_is_write,
    output logic                              o_error,
    output logic                              o_last,
    output logic [fcr_pkg::LBA_W-1:0]         o_chunk_lba,
    output logic [fcr_pkg::CYL_W-1:0]         o_cylinder,
    output logic                              o_head,
    output logic [fcr_pkg::SEC_W-1:0]         o_sector,
    output logic [fcr_pkg::SEC_W-1:0]         o_chunk_sectors,
    output logic [fcr_pkg::BYTE_W-1:0]        o_command_opcode,
    output logic [fcr_pkg::BYTE_W-1:0]        o_dma_mode,
    output logic [fcr_pkg::DMA_W-1:0]         o_dma_count_minus_one
);

    localparam logic [fcr_pkg::TRK_W-1:0] Track = fcr_pkg::TRK_W'(TRACK_SECTORS);
    localparam logic [fcr_pkg::LBA_W:0]   Total = (fcr_pkg::LBA_W + 1)'(TOTAL_SECTORS);
    localparam logic [fcr_pkg::CNT_W-1:0] MaxReq = fcr_pkg::CNT_W'(MAX_REQUEST);
    localparam logic [fcr_pkg::RECIP_W-1:0] Recip = fcr_pkg::RECIP_W'(
        ((1 << fcr_pkg::RECIP_SHIFT) + TRACK_SECTORS - 1) / TRACK_SECTORS);

    logic [fcr_pkg::LBA_W-1:0] r_lba;
    logic [fcr_pkg::CNT_W-1:0] r_left;
    logic                      r_wr;
    logic                      r_err;
    logic [fcr_pkg::LBA_W-1:0] r_quo;
    logic [fcr_pkg::TRK_W-1:0] r_rem;
    logic [fcr_pkg::K_W-1:0]   r_k;

    logic                       r_error;
    logic                       r_last;
    logic [fcr_pkg::LBA_W-1:0]  r_chunk_lba;
    logic [fcr_pkg::CYL_W-1:0]  r_cylinder;
    logic                       r_head;
    logic [fcr_pkg::SEC_W-1:0]  r_sector;
    logic [fcr_pkg::SEC_W-1:0]  r_chunk_sectors;
    logic [fcr_pkg::BYTE_W-1:0] r_command_opcode;
    logic [fcr_pkg::BYTE_W-1:0] r_dma_mode;
    logic [fcr_pkg::DMA_W-1:0]  r_dma_count_minus_one;

    logic                       bad;
    logic [fcr_pkg::LBA_W:0]    end_lba;
    logic [fcr_pkg::PROD_W-1:0] quo_prod;
    logic [fcr_pkg::LBA_W-1:0]  quo_back;
    logic [fcr_pkg::LBA_W-1:0]  rem_full;
    logic [fcr_pkg::TRK_W-1:0]  avail;
    logic                       fits;
    logic [fcr_pkg::TRK_W-1:0]  chunk_len;
    logic [fcr_pkg::TRK_W-1:0]  len_minus;
    logic [fcr_pkg::TRK_W-1:0]  sec_1b;
    logic                       chunk_last;

    // request check: the sum form avoids a negative remaining span
    assign end_lba = {1'b0, i_start_lba} + {1'b0, i_sector_count};
    assign bad = ({1'b0, i_start_lba} >= Total) || (i_sector_count == '0)
              || (end_lba > Total) || (i_sector_count > MaxReq);

    // quotient by reciprocal, remainder from the registered quotient
    assign quo_prod = fcr_pkg::PROD_W'(r_lba) * fcr_pkg::PROD_W'(Recip);
    assign quo_back = r_quo * {{(fcr_pkg::LBA_W - fcr_pkg::TRK_W){1'b0}}, Track};
    assign rem_full = r_lba - quo_back;

    // chunk size up to the track end
    assign avail     = Track - r_rem;
    assign fits      = r_left <= {{(fcr_pkg::CNT_W - fcr_pkg::TRK_W){1'b0}}, avail};
    assign chunk_len = fits ? r_left[fcr_pkg::TRK_W-1:0] : avail;
    assign len_minus = chunk_len - 1'b1;
    assign sec_1b    = r_rem + 1'b1;

    assign chunk_last = r_err || fits
                     || (r_k == fcr_pkg::K_W'(fcr_pkg::MAX_RESULTS - 1));
    assign o_status.chunk_last = chunk_last;

    assign o_error               = r_error;
    assign o_last                = r_last;
    assign o_chunk_lba           = r_chunk_lba;
    assign o_cylinder            = r_cylinder;
    assign o_head                = r_head;
    assign o_sector              = r_sector;
    assign o_chunk_sectors       = r_chunk_sectors;
    assign o_command_opcode      = r_command_opcode;
    assign o_dma_mode            = r_dma_mode;
    assign o_dma_count_minus_one = r_dma_count_minus_one;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_lba  <= i_start_lba;
            r_left <= i_sector_count;
            r_wr   <= i_is_write;
            r_err  <= bad;
            r_quo  <= '0;
            r_rem  <= '0;
            r_k    <= '0;
        end
        if (i_cmd.div_step) begin
            // second step sees the settled quotient
            r_quo <= quo_prod[fcr_pkg::RECIP_SHIFT +: fcr_pkg::LBA_W];
            r_rem <= rem_full[fcr_pkg::TRK_W-1:0];
        end
        if (i_cmd.emit) begin
            r_last  <= chunk_last;
            r_error <= r_err;
            if (r_err) begin
                r_chunk_lba           <= '0;
                r_cylinder            <= '0;
                r_head                <= 1'b0;
                r_sector              <= '0;
                r_chunk_sectors       <= '0;
                r_command_opcode      <= '0;
                r_dma_mode            <= '0;
                r_dma_count_minus_one <= '0;
            end else begin
                r_chunk_lba      <= r_lba;
                r_cylinder       <= r_quo[fcr_pkg::CYL_W:1];
                r_head           <= r_quo[0];
                r_sector         <= sec_1b[fcr_pkg::SEC_W-1:0];
                r_chunk_sectors  <= chunk_len[fcr_pkg::SEC_W-1:0];
                r_command_opcode <= r_wr ? fcr_pkg::OP_WRITE_DATA : fcr_pkg::OP_READ_DATA;
                r_dma_mode       <= r_wr ? fcr_pkg::DMA_MEM_TO_DEV : fcr_pkg::DMA_DEV_TO_MEM;
                r_dma_count_minus_one <=
                    {len_minus[fcr_pkg::DMA_W-fcr_pkg::BLK_SHIFT-1:0], fcr_pkg::BLK_LOW_ONES};
            end
            // advance to the next track boundary
            r_lba  <= r_lba + {{(fcr_pkg::LBA_W - fcr_pkg::TRK_W){1'b0}}, chunk_len};
            r_left <= r_left - {{(fcr_pkg::CNT_W - fcr_pkg::TRK_W){1'b0}}, chunk_len};
            r_k    <= r_k + 1'b1;
            if (!fits) begin
                r_rem <= '0;
                r_quo <= r_quo + 1'b1;
            end
        end
    end

endmodule

[hw/rtl/floppy_request_chunker.sv]
`timescale 1ns / 1ps

// channel | direction | handshake                 | word
// request | in        | i_in_valid / o_in_ready   | start lba, sector count, direction
// chunk   | out       | o_out_valid / i_out_ready | error, last, geometry, count, opcode, dma
//
// a request is taken while idle, then a reciprocal multiply and a remainder step give the track
// index and sector offset; after that one chunk per cycle enters the output register
// whenever it is free
// a rejected request also passes the divide and leaves as one error word
// i_rst_n is synchronous and active low; it clears the controller and the output valid
// a stalled output holds its word; the next request is taken once the last word is loaded

module floppy_request_chunker #(
    parameter int TOTAL_SECTORS = 2880,
    parameter int TRACK_SECTORS = 18,
    parameter int MAX_REQUEST   = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request channel
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [11:0] i_start_lba,
    input  logic [11:0] i_sector_count,
    input  logic        i_is_write,
    // chunk channel
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_error,
    output logic        o_last,
    output logic [11:0] o_chunk_lba,
    output logic [6:0]  o_cylinder,
    output logic        o_head,
    output logic [4:0]  o_sector,
    output logic [4:0]  o_chunk_sectors,
    output logic [7:0]  o_command_opcode,
    output logic [7:0]  o_dma_mode,
    output logic [13:0] o_dma_count_minus_one
);

    // command and status between the sequencer and the datapath
    fcr_pkg::t_cmd    cmd;
    fcr_pkg::t_status status;

    // sequencer: idle, divide, emit chunks
    fcr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    // request check, divider, chunk walker and output register
    fcr_dpath #(
        .TOTAL_SECTORS (TOTAL_SECTORS),
        .TRACK_SECTORS (TRACK_SECTORS),
        .MAX_REQUEST   (MAX_REQUEST)
    ) u_dpath (
        .i_clk                 (i_clk),
        .i_cmd                 (cmd),
        .o_status              (status),
        .i_start_lba           (i_start_lba),
        .i_sector_count        (i_sector_count),
        .i_is_write            (i_is_write),
        .o_error               (o_error),
        .o_last                (o_last),
        .o_chunk_lba           (o_chunk_lba),
        .o_cylinder            (o_cylinder),
        .o_head                (o_head),
        .o_sector              (o_sector),
        .o_chunk_sectors       (o_chunk_sectors),
        .o_command_opcode      (o_command_opcode),
        .o_dma_mode            (o_dma_mode),
        .o_dma_count_minus_one (o_dma_count_minus_one)
    );

endmodule

[hw/rtl/fcr_checker.sv]
`timescale 1ns / 1ps

module fcr_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic        o_error,
    input logic        o_last,
    input logic [11:0] o_chunk_lba,
    input logic [4:0]  o_sector,
    input logic [4:0]  o_chunk_sectors,
    input logic [13:0] o_dma_count_minus_one
);

    // nothing left over from before reset
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // a taken request drops input ready
    a_accept_drops_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input ready stayed high after a request");

    // a stalled word holds
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_chunk_lba)
            && $stable(o_last) && $stable(o_error))
        else $error("stalled word changed");

    // a rejection is a single closing word with zero fields
    a_error_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_error |-> o_last && o_chunk_lba == '0 && o_chunk_sectors == '0)
        else $error("malformed error word");

    // the dma byte count tracks the chunk length in whole sectors
    a_chunk_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_error |-> o_sector != '0
            && o_dma_count_minus_one[8:0] == 9'h1FF
            && o_dma_count_minus_one[13:9] == o_chunk_sectors - 5'd1)
        else $error("malformed chunk word");

endmodule

bind floppy_request_chunker fcr_checker u_fcr_checker (
    .i_clk                 (i_clk),
    .i_rst_n               (i_rst_n),
    .i_in_valid            (i_in_valid),
    .o_in_ready            (o_in_ready),
    .o_out_valid           (o_out_valid),
    .i_out_ready           (i_out_ready),
    .o_error               (o_error),
    .o_last                (o_last),
    .o_chunk_lba           (o_chunk_lba),
    .o_sector              (o_sector),
    .o_chunk_sectors       (o_chunk_sectors),
    .o_dma_count_minus_one (o_dma_count_minus_one)
);
